### rtl/ftic_pkg.sv
`default_nettype none
package ftic_pkg;

    localparam int RULE_COUNT      = 25;
    localparam int MEMBERSHIP_BITS = 12;
    localparam int MW              = MEMBERSHIP_BITS + 1;      // membership incl. 1.0
    localparam int SQW             = 2 * MEMBERSHIP_BITS + 5;  // up to 25 squares
    localparam int STW             = MEMBERSHIP_BITS + 3;      // class strength
    localparam int NUM_CLASSES     = 5;

    localparam logic [2:0] REG_ANGLE_A = 3'd0;
    localparam logic [2:0] REG_ANGLE_B = 3'd1;
    localparam logic [2:0] REG_ANGLE_C = 3'd2;
    localparam logic [2:0] REG_RATE_A  = 3'd3;
    localparam logic [2:0] REG_RATE_B  = 3'd4;
    localparam logic [2:0] REG_RATE_C  = 3'd5;
    localparam logic [2:0] REG_RULE_LO = 3'd6;
    localparam logic [2:0] REG_RULE_HI = 3'd7;

    // datapath operations
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_FUZZ    = 3'd1;
    localparam logic [2:0] OP_RULE    = 3'd2;
    localparam logic [2:0] OP_SQRT    = 3'd3;
    localparam logic [2:0] OP_DIV     = 3'd4;
    localparam logic [2:0] OP_LOAD    = 3'd5;

    typedef struct packed {
        logic signed [11:0] angle_sample;
        logic signed [11:0] rate_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [14:0] drive_value;
        logic               no_rule_fired;
    } t_out_item;

    typedef struct packed {
        logic [2:0] op;
        logic       start;   // first cycle of the op
        logic [4:0] idx;     // class or rule index
    } t_cmd;

    typedef struct packed {
        logic done;          // current iterative op finished
    } t_status;

    function automatic logic signed [7:0] class_weight(input logic [2:0] c);
        case (c)
            3'd0:    class_weight = -8'sd35;
            3'd1:    class_weight = -8'sd14;
            3'd3:    class_weight = 8'sd14;
            3'd4:    class_weight = 8'sd35;
            default: class_weight = 8'sd0;
        endcase
    endfunction

endpackage
`default_nettype wire

### rtl/ftic_ctrl.sv
`default_nettype none
module ftic_ctrl
    import ftic_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FUZZ = 3'd1;
    localparam logic [2:0] S_RULE = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [4:0] r_idx, n_idx;
    logic       r_start, n_start;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_start = 1'b0;
        o_cmd.op    = OP_NONE;
        o_cmd.start = r_start;
        o_cmd.idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state = S_FUZZ;
                    n_idx   = 5'd0;
                    n_start = 1'b1;
                end
            end
            S_FUZZ: begin
                // idx 0..4 angle classes, 5..9 rate classes
                o_cmd.op = OP_FUZZ;
                if (i_status.done) begin
                    n_start = 1'b1;
                    if (r_idx == 5'd9) begin
                        n_state = S_RULE;
                        n_idx   = 5'd0;
                    end else begin
                        n_idx = r_idx + 5'd1;
                    end
                end
            end
            S_RULE: begin
                o_cmd.op = OP_RULE;
                if (r_idx == 5'(RULE_COUNT - 1)) begin
                    n_state = S_SQRT;
                    n_idx   = 5'd0;
                    n_start = 1'b1;
                end else begin
                    n_idx = r_idx + 5'd1;
                end
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (i_status.done) begin
                    n_start = 1'b1;
                    if (r_idx == 5'd4) begin
                        n_state = S_DIV;
                    end else begin
                        n_idx = r_idx + 5'd1;
                    end
                end
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_status.done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= 5'd0;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_start <= n_start;
        end
    end

`ifndef SYNTHESIS
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall) else $error("input taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid) else $error("result dropped");
    a_idx_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RULE) |-> (r_idx < 5'(RULE_COUNT))) else $error("rule index");
`endif

endmodule
`default_nettype wire

### rtl/ftic_datapath.sv
`default_nettype none
module ftic_datapath
    import ftic_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_cfg_we,
    input  wire logic [2:0] i_cfg_idx,
    input  wire logic [59:0] i_cfg_data,
    input  wire t_in_item i_in,
    input  wire t_cmd     i_cmd,
    input  wire logic     i_rst_n,
    output t_status       o_status,
    output t_out_item     o_out
);

    logic [59:0] r_regs [0:7];
    t_in_item    r_in;
    logic [MW-1:0]  r_amu [0:4];
    logic [MW-1:0]  r_rmu [0:4];
    logic [SQW-1:0] r_sq  [0:4];
    logic [STW-1:0] r_st  [0:4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) r_regs[k] <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_RULE_HI) r_regs[i_cfg_idx] <= {45'd0, i_cfg_data[14:0]};
            else r_regs[i_cfg_idx] <= i_cfg_data;
        end
    end

    // ---------------- fuzzify: one class at a time, serial divider
    logic        fz_rate;
    logic [2:0]  fz_c;
    logic signed [11:0] fz_x, bp_l, bp_p, bp_r;
    logic [2:0]  fz_base;

    function automatic logic signed [11:0] bp(input logic [59:0] a, input logic [59:0] b,
                                              input logic [59:0] c, input logic [3:0] k);
        logic [59:0] w;
        logic [2:0]  s;
        w = (k < 4'd5) ? a : ((k < 4'd10) ? b : c);
        s = (k < 4'd5) ? 3'(k) : ((k < 4'd10) ? 3'(k - 4'd5) : 3'(k - 4'd10));
        bp = w[12*s +: 12];
    endfunction

    assign fz_rate = (i_cmd.idx >= 5'd5);
    assign fz_c    = fz_rate ? 3'(i_cmd.idx - 5'd5) : 3'(i_cmd.idx);
    assign fz_x    = fz_rate ? r_in.rate_sample : r_in.angle_sample;
    assign fz_base = fz_rate ? 3'd3 : 3'd0;

    always_comb begin
        bp_l = bp(r_regs[fz_base], r_regs[fz_base + 3'd1], r_regs[fz_base + 3'd2],
                  4'(3 * fz_c));
        bp_p = bp(r_regs[fz_base], r_regs[fz_base + 3'd1], r_regs[fz_base + 3'd2],
                  4'(3 * fz_c + 1));
        bp_r = bp(r_regs[fz_base], r_regs[fz_base + 3'd1], r_regs[fz_base + 3'd2],
                  4'(3 * fz_c + 2));
    end

    // shared restoring divider: quotient of numerator / denominator
    localparam int DNW = 32;
    logic [DNW-1:0] r_dv_rem, r_dv_den, r_dv_quo;
    logic [DNW-1:0] r_dv_num;
    logic [5:0]     r_dv_cnt;
    logic           r_dv_busy;
    logic           r_dv_neg;
    logic [DNW:0]   dv_trial;

    // membership decision, computed on start
    logic           fz_const;
    logic [MW-1:0]  fz_constv;
    logic [12:0]    fz_nume, fz_dene;

    always_comb begin
        fz_const  = 1'b1;
        fz_constv = '0;
        fz_nume   = '0;
        fz_dene   = 13'd1;
        if (fz_x < bp_p) begin
            if (fz_c == 3'd0) fz_constv = MW'(1 << MEMBERSHIP_BITS);
            else if (fz_x >= bp_l) begin
                fz_const = 1'b0;
                fz_nume  = 13'(fz_x - bp_l);
                fz_dene  = 13'(bp_p - bp_l);
            end
        end else begin
            if (fz_c == 3'd4) fz_constv = MW'(1 << MEMBERSHIP_BITS);
            else if (fz_x < bp_r) begin
                fz_const = 1'b0;
                fz_nume  = 13'(bp_r - fz_x);
                fz_dene  = 13'(bp_r - bp_p);
            end
        end
    end

    // ---------------- sqrt unit: two bits per cycle
    logic [SQW-1:0] r_sq_v, r_sq_res, r_sq_bit;
    logic           r_sq_busy;
    logic [SQW:0]   sq_t;

    // ---------------- final numerator and denominator
    logic signed [STW+8:0] r_num;
    logic [STW+2:0]        r_den;
    logic signed [STW+8:0] mac_num;
    logic [STW+2:0]        mac_den;

    always_comb begin
        mac_num = '0;
        mac_den = '0;
        for (int c = 0; c < 5; c++) begin
            mac_num = mac_num + (STW+9)'($signed({1'b0, r_st[c]}) * class_weight(3'(c)));
            mac_den = mac_den + (STW+3)'(r_st[c]);
        end
    end

    // rule strength
    logic [2:0]    ru_code;
    logic [MW-1:0] ru_a, ru_r, ru_s;
    logic [4:0]    ru_ai, ru_ri;
    always_comb begin
        // rate class is the rule index over five, found by range compares
        ru_ri = (i_cmd.idx >= 5'd20) ? 5'd4 :
                (i_cmd.idx >= 5'd15) ? 5'd3 :
                (i_cmd.idx >= 5'd10) ? 5'd2 :
                (i_cmd.idx >= 5'd5)  ? 5'd1 : 5'd0;
        ru_ai = i_cmd.idx - ru_ri * 5'd5;
        ru_code = (i_cmd.idx < 5'd20) ? r_regs[REG_RULE_LO][3*i_cmd.idx +: 3]
                                      : r_regs[REG_RULE_HI][3*(i_cmd.idx - 5'd20) +: 3];
        ru_a = r_amu[ru_ai[2:0]];
        ru_r = r_rmu[ru_ri[2:0]];
        ru_s = (ru_r < ru_a) ? ru_r : ru_a;
    end
    logic [2*MW-1:0] ru_sq;
    assign ru_sq = ru_s * ru_s;

    assign dv_trial = {r_dv_rem[DNW-2:0], r_dv_num[DNW-1]} - {1'b0, r_dv_den};
    assign sq_t = {1'b0, r_sq_v} - {1'b0, (r_sq_res + r_sq_bit)};

    always_comb begin
        o_status.done = 1'b0;
        case (i_cmd.op)
            OP_FUZZ: o_status.done = !i_cmd.start && (fz_const || (r_dv_busy && r_dv_cnt == 6'd0));
            OP_SQRT: o_status.done = !i_cmd.start && (r_sq_busy && r_sq_bit == '0);
            OP_DIV:  o_status.done = !i_cmd.start && (r_den == '0 ||
                                                      (r_dv_busy && r_dv_cnt == 6'd0));
            default: o_status.done = 1'b0;
        endcase
    end

    logic [DNW-1:0] dv_q_next, dv_r_next;
    always_comb begin
        if (!dv_trial[DNW]) begin
            dv_r_next = dv_trial[DNW-1:0];
            dv_q_next = {r_dv_quo[DNW-2:0], 1'b1};
        end else begin
            dv_r_next = {r_dv_rem[DNW-2:0], r_dv_num[DNW-1]};
            dv_q_next = {r_dv_quo[DNW-2:0], 1'b0};
        end
    end

    logic [DNW-1:0] dnum_abs;
    assign dnum_abs = r_num[STW+8] ? DNW'(-r_num) : DNW'(r_num);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_in <= i_in;
                for (int c = 0; c < 5; c++) r_sq[c] <= '0;
            end
            OP_FUZZ: begin
                if (i_cmd.start) begin
                    r_dv_busy <= !fz_const;
                    r_dv_num  <= DNW'(fz_nume) << MEMBERSHIP_BITS;
                    r_dv_den  <= DNW'(fz_dene);
                    r_dv_rem  <= '0;
                    r_dv_quo  <= '0;
                    r_dv_cnt  <= 6'(DNW);
                    if (fz_const) begin
                        if (fz_rate) r_rmu[fz_c] <= fz_constv;
                        else r_amu[fz_c] <= fz_constv;
                    end
                end else if (r_dv_busy && r_dv_cnt != 6'd0) begin
                    r_dv_rem <= dv_r_next;
                    r_dv_quo <= dv_q_next;
                    r_dv_num <= r_dv_num << 1;
                    r_dv_cnt <= r_dv_cnt - 6'd1;
                end else if (r_dv_busy) begin
                    r_dv_busy <= 1'b0;
                    if (fz_rate) r_rmu[fz_c] <= MW'(r_dv_quo);
                    else r_amu[fz_c] <= MW'(r_dv_quo);
                end
            end
            OP_RULE: begin
                if (ru_code < 3'd5) r_sq[ru_code] <= r_sq[ru_code] + SQW'(ru_sq);
            end
            OP_SQRT: begin
                if (i_cmd.start) begin
                    r_sq_busy <= 1'b1;
                    r_sq_v    <= r_sq[i_cmd.idx[2:0]];
                    r_sq_res  <= '0;
                    r_sq_bit  <= SQW'(1) << (SQW - 1 - ((SQW - 1) % 2));
                end else if (r_sq_bit != '0) begin
                    if (!sq_t[SQW]) begin
                        r_sq_v   <= sq_t[SQW-1:0];
                        r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                    end else begin
                        r_sq_res <= r_sq_res >> 1;
                    end
                    r_sq_bit <= r_sq_bit >> 2;
                end else begin
                    r_sq_busy <= 1'b0;
                    r_st[i_cmd.idx[2:0]] <= STW'(r_sq_res);
                    if (i_cmd.idx == 5'd4) begin
                        r_num <= '0;
                    end
                end
            end
            OP_DIV: begin
                if (i_cmd.start) begin
                    r_num <= mac_num;
                    r_den <= mac_den;
                    r_dv_busy <= 1'b0;
                end else if (!r_dv_busy && r_dv_cnt != 6'd63) begin
                    r_dv_busy <= 1'b1;
                    r_dv_neg  <= r_num[STW+8];
                    r_dv_num  <= dnum_abs << 8;
                    r_dv_den  <= DNW'(r_den);
                    r_dv_rem  <= '0;
                    r_dv_quo  <= '0;
                    r_dv_cnt  <= 6'(DNW);
                end else if (r_dv_busy && r_dv_cnt != 6'd0) begin
                    r_dv_rem <= dv_r_next;
                    r_dv_quo <= dv_q_next;
                    r_dv_num <= r_dv_num << 1;
                    r_dv_cnt <= r_dv_cnt - 6'd1;
                end
                if (r_den == '0 && !i_cmd.start) begin
                    o_out.drive_value   <= '0;
                    o_out.no_rule_fired <= 1'b1;
                end else if (r_dv_busy && r_dv_cnt == 6'd0) begin
                    r_dv_busy <= 1'b0;
                    o_out.drive_value   <= r_dv_neg ? -15'(r_dv_quo) : 15'(r_dv_quo);
                    o_out.no_rule_fired <= 1'b0;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

### rtl/fuzzy_two_input_controller_top.sv
// Steps per item, from accept to o_out_valid: each of the ten classes gives a constant
// membership or runs a 32-step slope division; the 25 rules are accumulated; five
// square roots follow; a final division runs, skipped when no rule fires.
// Items are handled one at a time; the next is taken the cycle after the result leaves.
// Reset: synchronous active-low i_rst_n clears the control state and the configuration registers to 0.
`default_nettype none
module fuzzy_two_input_controller_top
    import ftic_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [59:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    ftic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ftic_datapath u_dp (
        .i_clk      (i_clk),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_idx  (i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in_data),
        .i_cmd      (cmd),
        .i_rst_n    (i_rst_n),
        .o_status   (status),
        .o_out      (o_out_data)
    );

endmodule
`default_nettype wire
